### hw/rtl/stt_pkg.sv
// Shared types, codes and default sizes for the slot table timer engine.
package stt_pkg;

    localparam int SLOT_COUNT_DEF  = 8;
    localparam int TIMER_COUNT_DEF = 16;
    localparam int TICK_WIDTH_DEF  = 32;

    // Command codes carried in the func field.
    localparam logic [2:0] FUNC_SET_VALUE = 3'd0;
    localparam logic [2:0] FUNC_START     = 3'd1;
    localparam logic [2:0] FUNC_STOP      = 3'd2;
    localparam logic [2:0] FUNC_RESTART   = 3'd3;
    localparam logic [2:0] FUNC_INIT      = 3'd4;
    localparam logic [2:0] FUNC_TICK      = 3'd5;

    localparam logic KIND_ACK    = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    localparam logic [1:0] STATUS_SUCCESS      = 2'd0;
    localparam logic [1:0] STATUS_NO_SLOT      = 2'd1;
    localparam logic [1:0] STATUS_RUNNING      = 2'd2;
    localparam logic [1:0] STATUS_NONE_EXPIRED = 2'd3;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [2:0]  func;
        logic [3:0]  timer_id;
        logic [31:0] reload_value;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic       kind;
        logic [3:0] result_timer;
        logic [1:0] status;
        logic       running;
        logic       last;
    } out_item_t;

endpackage

### hw/rtl/stt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module stt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/stt_alu.sv
// Shared tick-width adder and subtractor for deadlines and expiry checks.
module stt_alu #(
    parameter int WIDTH = 32
) (
    input  stt_pkg::alu_op_t   op,
    input  logic [WIDTH-1:0]   a,
    input  logic [WIDTH-1:0]   b,
    output logic [WIDTH-1:0]   y
);

    always_comb begin
        case (op)
            stt_pkg::ALU_SUB: y = a - b;
            default:          y = a + b;
        endcase
    end

endmodule

### hw/rtl/slot_table_software_timers.sv
// Top level of the slot table timer engine: sequencer, flags and memories.
//
// Commands arrive on the s_ channel (valid/ready) as one in_item_t each and
// results leave on the m_ channel (valid/ready) as out_item_t. Every command
// but a tick or unused func code gives one acknowledgement; a tick gives one
// result per expired timer in slot order, or a single "nothing expired"
// result, and the last result of a command carries last = 1.
// The block takes one command at a time and drops s_ready until the final
// result of that command sits in the output register. Slot scans go through
// the slot owner memory one slot per cycle. A tick visits the slots in order:
// an empty slot is left after the used flag check, a slot whose timer is
// stopped after the owner read, and one whose timer runs goes through owner
// read, deadline read and a compare in the shared subtractor; a closing step
// then emits the final result. After aresetn every timer is stopped with zero
// reload and deadline and every slot is empty; no clearing pass is needed.
// When the receiver stalls, the output register holds its result and the
// sequencer waits before it loads the next one; no result is dropped.
module slot_table_software_timers #(
    parameter int SLOT_COUNT  = stt_pkg::SLOT_COUNT_DEF,
    parameter int TIMER_COUNT = stt_pkg::TIMER_COUNT_DEF,
    parameter int TICK_WIDTH  = stt_pkg::TICK_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stt_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output stt_pkg::out_item_t m_data
);

    localparam int SIDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int SCNT_W = $clog2(SLOT_COUNT + 1);
    localparam int TID_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_SCAN   = 9'b000000010,
        ST_RLD    = 9'b000000100,
        ST_DLN    = 9'b000001000,
        ST_EMIT   = 9'b000010000,
        ST_TK_RD  = 9'b000100000,
        ST_TK_OWN = 9'b001000000,
        ST_TK_CMP = 9'b010000000,
        ST_TK_END = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Control state.
    logic [SLOT_COUNT-1:0]  used_reg, used_next;
    logic [TIMER_COUNT-1:0] run_reg, run_next;
    logic [TIMER_COUNT-1:0] rl_vld_reg, rl_vld_next;
    logic [TIMER_COUNT-1:0] dl_vld_reg, dl_vld_next;
    logic                   m_valid_reg, m_valid_next;
    logic                   pend_vld_reg, pend_vld_next;
    logic                   cmp_vld_reg, cmp_vld_next;

    // Payload and working registers.
    stt_pkg::in_item_t      cmd_reg, cmd_next;
    logic [TID_W-1:0]       tidx_reg, tidx_next;
    logic                   in_range_reg, in_range_next;
    logic [TICK_WIDTH-1:0]  now_reg, now_next;
    logic [SCNT_W-1:0]      iss_idx_reg, iss_idx_next;
    logic [SIDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic [SIDX_W-1:0]      tk_idx_reg, tk_idx_next;
    logic                   scan_start_reg, scan_start_next;
    logic [1:0]             status_reg, status_next;
    logic [TID_W-1:0]       pend_reg, pend_next;
    logic                   rl_vld_q_reg, dl_vld_q_reg;
    stt_pkg::out_item_t     m_data_reg, m_data_next;

    // Memory ports.
    logic                   own_we;
    logic [SIDX_W-1:0]      own_raddr;
    logic [TID_W-1:0]       owner_q;
    logic                   rl_we;
    logic [31:0]            rl_wdata, rl_q;
    logic                   dl_we;
    logic [TID_W-1:0]       dl_raddr;
    logic [TICK_WIDTH-1:0]  dl_q;

    // Shared arithmetic.
    stt_pkg::alu_op_t       alu_op;
    logic [TICK_WIDTH-1:0]  alu_b, alu_y;

    logic [TID_W+3:0]       in_tid_ext;
    logic [TID_W-1:0]       in_tidx;
    logic                   in_in_range;
    logic [TICK_WIDTH+31:0] in_now_ext;
    logic [31:0]            reload_eff;
    logic [TICK_WIDTH+31:0] reload_ext;
    logic [TICK_WIDTH-1:0]  deadline_eff;
    logic [TID_W+3:0]       pend_ext;
    logic                   iss_more;
    logic                   tk_last;
    logic                   out_free;
    logic                   expired;

    assign in_tid_ext  = {TID_W'(0), s_data.timer_id};
    assign in_tidx     = in_tid_ext[TID_W-1:0];
    assign in_in_range = ({28'd0, s_data.timer_id} < 32'(TIMER_COUNT));
    assign in_now_ext  = {TICK_WIDTH'(0), s_data.now_ms};

    // Entries never written since reset or init read as zero.
    assign reload_eff   = rl_vld_q_reg ? rl_q : 32'd0;
    assign reload_ext   = {TICK_WIDTH'(0), reload_eff};
    assign deadline_eff = dl_vld_q_reg ? dl_q : '0;
    assign pend_ext     = {4'd0, pend_reg};

    assign iss_more = (iss_idx_reg < SCNT_W'(SLOT_COUNT));
    assign tk_last  = (tk_idx_reg == SIDX_W'(SLOT_COUNT - 1));
    assign out_free = !m_valid_reg || m_ready;

    assign alu_op  = (state_reg == ST_TK_CMP) ? stt_pkg::ALU_SUB : stt_pkg::ALU_ADD;
    assign alu_b   = (state_reg == ST_TK_CMP) ? deadline_eff : reload_ext[TICK_WIDTH-1:0];
    assign expired = !alu_y[TICK_WIDTH-1];

    assign own_raddr = (state_reg == ST_SCAN) ? (iss_more ? iss_idx_reg[SIDX_W-1:0] : '0)
                                              : tk_idx_reg;
    // The deadline of the slot owner stays on the read port while a compare waits.
    assign dl_raddr  = (state_reg == ST_TK_OWN || state_reg == ST_TK_CMP) ? owner_q : tidx_reg;
    assign rl_wdata  = (cmd_reg.reload_value == 32'd0) ? 32'd1 : cmd_reg.reload_value;

    stt_alu #(
        .WIDTH (TICK_WIDTH)
    ) u_alu (
        .op (alu_op),
        .a  (now_reg),
        .b  (alu_b),
        .y  (alu_y)
    );

    stt_ram #(
        .WIDTH (TID_W),
        .DEPTH (SLOT_COUNT)
    ) u_owner_ram (
        .aclk    (aclk),
        .wr_en   (own_we),
        .wr_addr (cmp_idx_reg),
        .wr_data (tidx_reg),
        .rd_addr (own_raddr),
        .rd_data (owner_q)
    );

    stt_ram #(
        .WIDTH (32),
        .DEPTH (TIMER_COUNT)
    ) u_reload_ram (
        .aclk    (aclk),
        .wr_en   (rl_we),
        .wr_addr (tidx_reg),
        .wr_data (rl_wdata),
        .rd_addr (tidx_reg),
        .rd_data (rl_q)
    );

    stt_ram #(
        .WIDTH (TICK_WIDTH),
        .DEPTH (TIMER_COUNT)
    ) u_deadline_ram (
        .aclk    (aclk),
        .wr_en   (dl_we),
        .wr_addr (tidx_reg),
        .wr_data (alu_y),
        .rd_addr (dl_raddr),
        .rd_data (dl_q)
    );

    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        run_next        = run_reg;
        rl_vld_next     = rl_vld_reg;
        dl_vld_next     = dl_vld_reg;
        pend_vld_next   = pend_vld_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmd_next        = cmd_reg;
        tidx_next       = tidx_reg;
        in_range_next   = in_range_reg;
        now_next        = now_reg;
        iss_idx_next    = iss_idx_reg;
        cmp_idx_next    = cmp_idx_reg;
        tk_idx_next     = tk_idx_reg;
        scan_start_next = scan_start_reg;
        status_next     = status_reg;
        pend_next       = pend_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        own_we          = 1'b0;
        rl_we           = 1'b0;
        dl_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_next        = s_data;
                    tidx_next       = in_tidx;
                    in_range_next   = in_in_range;
                    now_next        = in_now_ext[TICK_WIDTH-1:0];
                    status_next     = stt_pkg::STATUS_SUCCESS;
                    iss_idx_next    = '0;
                    cmp_vld_next    = 1'b0;
                    tk_idx_next     = '0;
                    scan_start_next = 1'b0;
                    pend_vld_next   = 1'b0;
                    unique case (s_data.func) inside
                        stt_pkg::FUNC_TICK: begin
                            state_next = ST_TK_RD;
                        end
                        stt_pkg::FUNC_SET_VALUE, stt_pkg::FUNC_START, stt_pkg::FUNC_STOP,
                        stt_pkg::FUNC_RESTART, stt_pkg::FUNC_INIT: begin
                            if (!in_in_range) begin
                                state_next = ST_EMIT;
                            end else if (s_data.func == stt_pkg::FUNC_INIT) begin
                                // Init forgets the values but leaves the slots alone.
                                rl_vld_next[in_tidx] = 1'b0;
                                dl_vld_next[in_tidx] = 1'b0;
                                run_next[in_tidx]    = 1'b0;
                                state_next           = ST_EMIT;
                            end else if (s_data.func == stt_pkg::FUNC_START) begin
                                if (run_reg[in_tidx]) begin
                                    status_next = stt_pkg::STATUS_RUNNING;
                                    state_next  = ST_EMIT;
                                end else begin
                                    state_next = ST_RLD;
                                end
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // Owner reads are issued one slot ahead of the compare.
                if (iss_more) begin
                    iss_idx_next = iss_idx_reg + SCNT_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = iss_idx_reg[SIDX_W-1:0];
                end else begin
                    cmp_vld_next = 1'b0;
                end
                if (scan_start_reg) begin
                    if (cmp_vld_reg && (!used_reg[cmp_idx_reg] || owner_q == tidx_reg)) begin
                        used_next[cmp_idx_reg] = 1'b1;
                        own_we                 = 1'b1;
                        run_next[tidx_reg]     = 1'b1;
                        cmp_vld_next           = 1'b0;
                        status_next            = stt_pkg::STATUS_SUCCESS;
                        state_next             = ST_EMIT;
                    end else if (!cmp_vld_reg && !iss_more) begin
                        status_next = stt_pkg::STATUS_NO_SLOT;
                        state_next  = ST_EMIT;
                    end
                end else begin
                    if (cmp_vld_reg && used_reg[cmp_idx_reg] && owner_q == tidx_reg) begin
                        used_next[cmp_idx_reg] = 1'b0;
                    end
                    if (!cmp_vld_reg && !iss_more) begin
                        run_next[tidx_reg] = 1'b0;
                        if (cmd_reg.func == stt_pkg::FUNC_SET_VALUE) begin
                            rl_we                 = 1'b1;
                            rl_vld_next[tidx_reg] = 1'b1;
                            state_next            = ST_EMIT;
                        end else if (cmd_reg.func == stt_pkg::FUNC_RESTART) begin
                            state_next = ST_RLD;
                        end else begin
                            state_next = ST_EMIT;
                        end
                    end
                end
            end

            ST_RLD: begin
                state_next = ST_DLN;
            end

            ST_DLN: begin
                // The deadline is updated even if no slot turns out to be free.
                dl_we                 = 1'b1;
                dl_vld_next[tidx_reg] = 1'b1;
                iss_idx_next          = '0;
                cmp_vld_next          = 1'b0;
                scan_start_next       = 1'b1;
                state_next            = ST_SCAN;
            end

            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_data_next.kind         = stt_pkg::KIND_ACK;
                    m_data_next.result_timer = cmd_reg.timer_id;
                    m_data_next.status       = status_reg;
                    m_data_next.running      = in_range_reg && run_reg[tidx_reg];
                    m_data_next.last         = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            ST_TK_RD: begin
                if (used_reg[tk_idx_reg]) begin
                    state_next = ST_TK_OWN;
                end else if (tk_last) begin
                    state_next = ST_TK_END;
                end else begin
                    tk_idx_next = tk_idx_reg + SIDX_W'(1);
                    state_next  = ST_TK_RD;
                end
            end

            ST_TK_OWN: begin
                if (run_reg[owner_q]) begin
                    state_next = ST_TK_CMP;
                end else if (tk_last) begin
                    state_next = ST_TK_END;
                end else begin
                    tk_idx_next = tk_idx_reg + SIDX_W'(1);
                    state_next  = ST_TK_RD;
                end
            end

            ST_TK_CMP: begin
                // An expiry is held back one step so that the final one can carry last.
                if (!expired || !pend_vld_reg || out_free) begin
                    if (expired) begin
                        if (pend_vld_reg) begin
                            m_valid_next             = 1'b1;
                            m_data_next.kind         = stt_pkg::KIND_EXPIRY;
                            m_data_next.result_timer = pend_ext[3:0];
                            m_data_next.status       = stt_pkg::STATUS_SUCCESS;
                            m_data_next.running      = 1'b0;
                            m_data_next.last         = 1'b0;
                        end
                        pend_next             = owner_q;
                        pend_vld_next         = 1'b1;
                        used_next[tk_idx_reg] = 1'b0;
                        run_next[owner_q]     = 1'b0;
                    end
                    if (tk_last) begin
                        state_next = ST_TK_END;
                    end else begin
                        tk_idx_next = tk_idx_reg + SIDX_W'(1);
                        state_next  = ST_TK_RD;
                    end
                end
            end

            ST_TK_END: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_data_next.kind    = stt_pkg::KIND_EXPIRY;
                    m_data_next.running = 1'b0;
                    m_data_next.last    = 1'b1;
                    if (pend_vld_reg) begin
                        m_data_next.result_timer = pend_ext[3:0];
                        m_data_next.status       = stt_pkg::STATUS_SUCCESS;
                    end else begin
                        m_data_next.result_timer = 4'd0;
                        m_data_next.status       = stt_pkg::STATUS_NONE_EXPIRED;
                    end
                    pend_vld_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            used_reg     <= '0;
            run_reg      <= '0;
            rl_vld_reg   <= '0;
            dl_vld_reg   <= '0;
            m_valid_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
            cmp_vld_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            used_reg     <= used_next;
            run_reg      <= run_next;
            rl_vld_reg   <= rl_vld_next;
            dl_vld_reg   <= dl_vld_next;
            m_valid_reg  <= m_valid_next;
            pend_vld_reg <= pend_vld_next;
            cmp_vld_reg  <= cmp_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        tidx_reg       <= tidx_next;
        in_range_reg   <= in_range_next;
        now_reg        <= now_next;
        iss_idx_reg    <= iss_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        tk_idx_reg     <= tk_idx_next;
        scan_start_reg <= scan_start_next;
        status_reg     <= status_next;
        pend_reg       <= pend_next;
        m_data_reg     <= m_data_next;
        // Valid marks follow the memory reads so that both land in the same cycle.
        rl_vld_q_reg   <= rl_vld_reg[tidx_reg];
        dl_vld_q_reg   <= dl_vld_reg[dl_raddr];
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Between commands each running timer owns at least one slot that no other
    // running timer owns.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ($countones(run_reg) <= $countones(used_reg)))
        else $error("more running timers than occupied slots");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pend_vld_reg |-> (state_reg == ST_TK_RD || state_reg == ST_TK_OWN ||
                          state_reg == ST_TK_CMP || state_reg == ST_TK_END))
        else $error("held expiry outside a tick");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> (state_reg == ST_SCAN))
        else $error("slot compare pending outside a scan");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free) |=> (m_valid && state_reg == ST_IDLE))
        else $error("acknowledgement not placed in the output register");

endmodule
